FILE: rtl/spd_pkg.sv
package spd_pkg;

    localparam int CAPACITY_DEF       = 16;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int PRIORITY_WIDTH_DEF = 16;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_SORT  = 3'd2,
        FN_REM_FRONT = 3'd3,
        FN_REM_BACK  = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } t_dp_cmd;

endpackage

FILE: rtl/sorted_priority_deque_top.sv
// Ordered store of value/priority pairs, up to CAPACITY entries, front at position 0.
// Raise start with func, item_value and item_priority while busy is low; the request is
// taken at that edge. busy then stays high through a compare state (in which every entry
// checks its priority against the new one in parallel) and a commit state (in which the
// entries to be moved shift together), and the result appears on the cycle after the commit
// state with o_valid high for exactly one cycle. The receiver cannot stall: capture the
// result when o_valid is high. A new request is taken in that same cycle, but none while
// busy is high. Sorted inserts go ahead of the first entry of strictly greater priority,
// keeping equal priorities in arrival order.
module sorted_priority_deque_top
    import spd_pkg::*;
#(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int CNT_W          = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [VALUE_WIDTH-1:0]    i_item_value,
    input  logic [PRIORITY_WIDTH-1:0] i_item_priority,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [VALUE_WIDTH-1:0]    o_removed_value,
    output logic [PRIORITY_WIDTH-1:0] o_removed_priority,
    output logic [CNT_W-1:0]          o_occupancy
);

    t_dp_cmd cmd;

    spd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    spd_dp #(
        .CAPACITY       (CAPACITY),
        .VALUE_WIDTH    (VALUE_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .CNT_W          (CNT_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_func             (i_func),
        .i_item_value       (i_item_value),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_removed_value    (o_removed_value),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

endmodule

FILE: rtl/spd_ctrl.sv
module spd_ctrl
    import spd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        busy          = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/spd_dp.sv
module spd_dp
    import spd_pkg::*;
#(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    parameter int CNT_W          = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [VALUE_WIDTH-1:0]    i_item_value,
    input  logic [PRIORITY_WIDTH-1:0] i_item_priority,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [VALUE_WIDTH-1:0]    o_removed_value,
    output logic [PRIORITY_WIDTH-1:0] o_removed_priority,
    output logic [CNT_W-1:0]          o_occupancy
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // request held for the duration of the operation
    logic [FUNC_W-1:0]         r_func;
    logic [VALUE_WIDTH-1:0]    r_val;
    logic [PRIORITY_WIDTH-1:0] r_pri;

    logic [VALUE_WIDTH-1:0]    r_val_q [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] r_pri_q [CAPACITY];
    logic [CAPACITY-1:0]       r_lt;
    logic [CNT_W-1:0]          r_cnt;

    logic                      r_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [VALUE_WIDTH-1:0]    r_rv;
    logic [PRIORITY_WIDTH-1:0] r_rp;

    logic                      full;
    logic                      empty;
    logic                      ins_ok;
    logic                      rem_front_ok;
    logic                      rem_back_ok;
    logic [CAPACITY-1:0]       cnt_oh;
    logic [CAPACITY-1:0]       pos_vec;
    logic [CAPACITY-1:0]       first;
    logic [CAPACITY-1:0]       ge;
    logic [CNT_W-1:0]          cnt_m1;
    logic [IDX_W-1:0]          back_idx;
    logic [CNT_W-1:0]          n_cnt;
    logic [STATUS_W-1:0]       n_status;
    logic [VALUE_WIDTH-1:0]    n_rv;
    logic [PRIORITY_WIDTH-1:0] n_rp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_val  <= i_item_value;
            r_pri  <= i_item_priority;
        end
    end

    assign full     = (r_cnt == CNT_W'(CAPACITY));
    assign empty    = (r_cnt == '0);
    assign cnt_oh   = CAPACITY'(1) << r_cnt;
    assign cnt_m1   = r_cnt - 1'b1;
    assign back_idx = cnt_m1[IDX_W-1:0];

    always_comb begin
        ins_ok       = 1'b0;
        rem_front_ok = 1'b0;
        rem_back_ok  = 1'b0;
        pos_vec      = cnt_oh;
        n_cnt        = r_cnt;
        n_status     = ST_OK;
        n_rv         = '0;
        n_rp         = '0;
        unique case (r_func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_SORT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (r_func == FN_INS_FRONT) begin
                    pos_vec = CAPACITY'(1);
                end else if (r_func == FN_INS_SORT) begin
                    // first held entry of strictly greater priority, else the back
                    pos_vec = r_lt | cnt_oh;
                end
            end
            FN_REM_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rem_front_ok = 1'b1;
                    n_cnt        = cnt_m1;
                    n_rv         = r_val_q[0];
                    n_rp         = r_pri_q[0];
                end
            end
            FN_REM_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rem_back_ok = 1'b1;
                    n_cnt       = cnt_m1;
                    n_rv        = r_val_q[back_idx];
                    n_rp        = r_pri_q[back_idx];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // isolate lowest set bit, then mark every cell at or above it
    assign first = pos_vec & (~pos_vec + 1'b1);
    assign ge    = ~(first - 1'b1);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic below;
        assign below = (CNT_W'(i) < r_cnt);

        always_ff @(posedge i_clk) begin
            if (i_cmd.compare) begin
                r_lt[i] <= below && (r_pri < r_pri_q[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.commit && ins_ok && first[i]) begin
                r_val_q[i] <= r_val;
                r_pri_q[i] <= r_pri;
            end else if (i_cmd.commit && ins_ok && ge[i] && (i > 0)) begin
                r_val_q[i] <= r_val_q[(i > 0) ? i - 1 : 0];
                r_pri_q[i] <= r_pri_q[(i > 0) ? i - 1 : 0];
            end else if (i_cmd.commit && rem_front_ok && (i < CAPACITY - 1)) begin
                r_val_q[i] <= r_val_q[(i < CAPACITY - 1) ? i + 1 : i];
                r_pri_q[i] <= r_pri_q[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_rv     <= n_rv;
            r_rp     <= n_rp;
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_removed_value    = r_rv;
    assign o_removed_priority = r_rp;
    assign o_occupancy        = r_cnt;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_valid)
        else $error("commit without result strobe");

    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && ins_ok) |-> $onehot(first))
        else $error("insert position not one-hot");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && ins_ok) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("insert did not advance occupancy");

    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (rem_front_ok || rem_back_ok)) |=>
            (r_cnt == $past(r_cnt) - 1'b1))
        else $error("removal did not drop occupancy");
`endif

endmodule
